>>> rtl/ffra_pkg.sv
// ----------------------------------------------------------------------------
// ffra_pkg: shared types and constants for the first-fit region allocator
// Table geometry, granule size, status codes and sequencer states.
// ----------------------------------------------------------------------------
package ffra_pkg;

    localparam int FREE_SLOTS = 64;
    localparam int MIN_REGION = 4096;
    localparam int IDX_W = $clog2(FREE_SLOTS);
    localparam int CNT_W = $clog2(FREE_SLOTS + 1);
    localparam logic [31:0] POOL_RESET = 32'd268435456;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_OOM  = 2'd1,
        ST_FULL = 2'd2,
        ST_ZERO = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_SCAN_CHK,
        S_SHIFT_DN,
        S_FIND,
        S_FIND_CHK,
        S_SHIFT_UP,
        S_PREV_RD,
        S_NEXT_RD,
        S_MERGE,
        S_DONE
    } state_t;

endpackage

>>> rtl/ffra_table.sv
// ----------------------------------------------------------------------------
// ffra_table: free table storage
// Offset and size memories, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module ffra_table
    import ffra_pkg::*;
(
    input  logic             clk,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_idx,
    input  logic [31:0]      wr_off,
    input  logic [31:0]      wr_size,
    input  logic [IDX_W-1:0] rd_idx,
    output logic [31:0]      rd_off,
    output logic [31:0]      rd_size
);

    logic [31:0] off_mem  [FREE_SLOTS];
    logic [31:0] size_mem [FREE_SLOTS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            off_mem[wr_idx]  <= wr_off;
            size_mem[wr_idx] <= wr_size;
        end
        rd_off  <= off_mem[rd_idx];
        rd_size <= size_mem[rd_idx];
    end

endmodule

>>> rtl/first_fit_region_allocator_unit.sv
// Acquire scans the free table slot by slot and, on a hit, shifts the later slots down;
// release compares slots to find the insert position, shifts slots up, reads both
// neighbours, merges, and shifts slots down after a merge; zero-size or table-full release
// goes straight to done. One item at a time: a new item is accepted only in idle, and the
// time per item is set by the single read port of the free table memory. A result
// not yet taken holds the sequencer in S_DONE. Reset: asynchronous, clears slot
// count, bump pointer, pool size to default.
// ----------------------------------------------------------------------------
// first_fit_region_allocator_unit: first-fit free-table region allocator
// Sequencer walks a memory-resident sorted free table for acquire/release.
// ----------------------------------------------------------------------------
module first_fit_region_allocator_unit
    import ffra_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        opcode,
    input  logic [31:0] region_size,
    input  logic [31:0] region_offset,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [31:0] granted_offset,
    output logic [31:0] granted_size
);

    state_t state_reg, state_next;
    logic [31:0] pool_reg, bump_reg, bump_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] k_reg, k_next;       // walking index
    logic [CNT_W-1:0] pos_reg, pos_next;
    logic [CNT_W-1:0] end_reg, end_next;   // shift-down limit
    logic [32:0] need_reg, need_next;
    logic [31:0] off_reg, off_next, size_reg, size_next;
    logic [31:0] poff_reg, poff_next, psize_reg, psize_next;
    logic        pmerge_reg, pmerge_next;
    logic        mode_reg, mode_next;      // acquire: 1 when granted from the table
    logic        skip_reg, skip_next;      // shift-down reads two slots ahead
    logic        opcode_reg;

    logic        ov_reg, ov_next;
    logic [1:0]  st_reg, st_next;
    logic [31:0] go_reg, go_next, gs_reg, gs_next;
    logic [1:0]  out_st_reg, out_st_next;
    logic [31:0] out_off_reg, out_off_next, out_size_reg, out_size_next;

    logic             wr_en;
    logic [IDX_W-1:0] wr_idx, rd_idx;
    logic [31:0]      wr_off, wr_size, rd_off, rd_size;

    // shift-down uses a two-phase read/write per slot folded into one state: phase 0
    // issues the read of k+1 (k+2 when skipping), phase 1 writes k with that read.
    logic sh_phase_reg, sh_phase_next;

    ffra_table u_table (
        .clk(clk), .wr_en(wr_en), .wr_idx(wr_idx), .wr_off(wr_off),
        .wr_size(wr_size), .rd_idx(rd_idx), .rd_off(rd_off), .rd_size(rd_size)
    );

    logic [32:0] req_round;
    logic [32:0] bump_sum;
    logic [32:0] end_sum, msum;

    assign req_round = ({1'b0, region_size} + 33'(MIN_REGION - 1))
                       / 33'(MIN_REGION) * 33'(MIN_REGION);
    assign bump_sum  = {1'b0, bump_reg} + need_reg;

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = ov_reg;
    assign status    = out_st_reg;
    assign granted_offset = out_off_reg;
    assign granted_size   = out_size_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    if (!opcode)
                        state_next = (cnt_reg == '0) ? S_DONE : S_SCAN;
                    else if (region_size == '0 || cnt_reg == CNT_W'(FREE_SLOTS))
                        state_next = S_DONE;
                    else
                        state_next = (cnt_reg == '0) ? S_SHIFT_UP : S_FIND;
                end
            end
            S_SCAN:     state_next = S_SCAN_CHK;
            S_SCAN_CHK:
            begin
                if ({1'b0, rd_size} >= need_reg)
                    state_next = (k_reg + 1'b1 < cnt_reg) ? S_SHIFT_DN : S_DONE;
                else
                    state_next = (k_reg + 1'b1 < cnt_reg) ? S_SCAN : S_DONE;
            end
            S_SHIFT_DN:
                state_next = (sh_phase_reg && k_reg + 1'b1 >= end_reg) ?
                             S_DONE : S_SHIFT_DN;
            S_FIND:     state_next = S_FIND_CHK;
            S_FIND_CHK:
            begin
                if (rd_off <= off_reg && k_reg + 1'b1 < cnt_reg)
                    state_next = S_FIND;
                else
                    state_next = S_SHIFT_UP;
            end
            S_SHIFT_UP:
                state_next = (k_reg == pos_reg) ? S_PREV_RD : S_SHIFT_UP;
            S_PREV_RD:  state_next = S_NEXT_RD;
            S_NEXT_RD:  state_next = S_MERGE;
            S_MERGE:    state_next = S_DONE;
            S_DONE:     state_next = (!ov_reg || out_ready) ? S_IDLE : S_DONE;
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        bump_next = bump_reg;  cnt_next = cnt_reg;  k_next = k_reg;
        pos_next = pos_reg;    end_next = end_reg;  need_next = need_reg;
        off_next = off_reg;    size_next = size_reg;
        poff_next = poff_reg;  psize_next = psize_reg; pmerge_next = pmerge_reg;
        mode_next = mode_reg;  sh_phase_next = sh_phase_reg; skip_next = skip_reg;
        ov_next = ov_reg;      st_next = st_reg; go_next = go_reg; gs_next = gs_reg;
        out_st_next = out_st_reg; out_off_next = out_off_reg;
        out_size_next = out_size_reg;
        wr_en = 1'b0; wr_idx = k_reg[IDX_W-1:0]; wr_off = rd_off; wr_size = rd_size;
        rd_idx = k_reg[IDX_W-1:0];
        end_sum = '0; msum = '0;
        if (ov_reg && out_ready)
            ov_next = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    k_next = '0; pos_next = '0; mode_next = 1'b0; sh_phase_next = 1'b0;
                    off_next = region_offset; size_next = region_size;
                    need_next = (req_round < 33'(MIN_REGION)) ? 33'(MIN_REGION) : req_round;
                    go_next = '0; gs_next = '0; st_next = ST_OK;
                    if (opcode)
                    begin
                        if (region_size == '0)
                            st_next = ST_ZERO;
                        else if (cnt_reg == CNT_W'(FREE_SLOTS))
                            st_next = ST_FULL;
                    end
                    mode_next = opcode;
                end
            end
            S_SCAN: rd_idx = k_reg[IDX_W-1:0];
            S_SCAN_CHK:
            begin
                if ({1'b0, rd_size} >= need_reg)
                begin
                    go_next = rd_off; gs_next = rd_size; st_next = ST_OK;
                    cnt_next = cnt_reg - 1'b1;
                    end_next = cnt_reg - 1'b1;
                    sh_phase_next = 1'b0;
                    skip_next = 1'b0;
                    k_next = k_reg;
                    // mark grant so DONE skips bump
                    mode_next = 1'b1;
                end
                else
                    k_next = k_reg + 1'b1;
            end
            S_SHIFT_DN:
            begin
                // phase 0: read source slot; phase 1: write k, advance
                if (!sh_phase_reg)
                begin
                    rd_idx = IDX_W'(k_reg + (skip_reg ? CNT_W'(2) : CNT_W'(1)));
                    sh_phase_next = 1'b1;
                end
                else
                begin
                    wr_en = 1'b1; wr_idx = k_reg[IDX_W-1:0];
                    k_next = k_reg + 1'b1; sh_phase_next = 1'b0;
                end
            end
            S_FIND: rd_idx = k_reg[IDX_W-1:0];
            S_FIND_CHK:
            begin
                if (rd_off <= off_reg)
                    pos_next = k_reg + 1'b1;
                else
                    pos_next = k_reg;
                if (rd_off <= off_reg && k_reg + 1'b1 < cnt_reg)
                    k_next = k_reg + 1'b1;
                else
                    k_next = cnt_reg;
                sh_phase_next = 1'b0;
            end
            S_SHIFT_UP:
            begin
                if (k_reg == pos_reg)
                begin
                    wr_en = 1'b1; wr_idx = pos_reg[IDX_W-1:0];
                    wr_off = off_reg; wr_size = size_reg;
                    cnt_next = cnt_reg + 1'b1;
                end
                else if (!sh_phase_reg)
                begin
                    rd_idx = IDX_W'(k_reg - 1'b1);
                    sh_phase_next = 1'b1;
                end
                else
                begin
                    wr_en = 1'b1; wr_idx = k_reg[IDX_W-1:0];
                    k_next = k_reg - 1'b1; sh_phase_next = 1'b0;
                end
            end
            S_PREV_RD: rd_idx = IDX_W'(pos_reg - 1'b1);
            S_NEXT_RD:
            begin
                rd_idx = IDX_W'(pos_reg + 1'b1);
                end_sum = {1'b0, rd_off} + {1'b0, rd_size};
                msum = {1'b0, rd_size} + {1'b0, size_reg};
                poff_next = rd_off; psize_next = rd_size;
                pmerge_next = (pos_reg != '0) && (end_sum == {1'b0, off_reg})
                              && !msum[32];
            end
            S_MERGE:
            begin
                // rd_* holds slot pos+1 (valid if pos+1 < cnt)
                end_sum = {1'b0, off_reg} + {1'b0, size_reg};
                if (pmerge_reg)
                    end_sum = {1'b0, poff_reg} + {1'b0, psize_reg} + {1'b0, size_reg};
                msum = (pmerge_reg ? ({1'b0, psize_reg} + {1'b0, size_reg})
                                   : {1'b0, size_reg}) + {1'b0, rd_size};
                if (pos_reg + 1'b1 < cnt_reg && end_sum == {1'b0, rd_off} && !msum[32])
                begin
                    // three-way or right merge: write merged at left slot, drop pos+1 (and pos on three-way)
                    wr_en = 1'b1;
                    wr_idx = pmerge_reg ? IDX_W'(pos_reg - 1'b1) : pos_reg[IDX_W-1:0];
                    wr_off = pmerge_reg ? poff_reg : off_reg;
                    wr_size = msum[31:0];
                    // remove pos and pos+1 (merged) or just pos+1
                    k_next = pmerge_reg ? pos_reg : pos_reg + 1'b1;
                    cnt_next = pmerge_reg ? cnt_reg - CNT_W'(2) : cnt_reg - 1'b1;
                    end_next = cnt_next;
                    skip_next = pmerge_reg;
                    pmerge_next = pmerge_reg;
                    mode_next = 1'b0;
                end
                else if (pmerge_reg)
                begin
                    wr_en = 1'b1; wr_idx = IDX_W'(pos_reg - 1'b1);
                    wr_off = poff_reg; wr_size = psize_reg + size_reg;
                    k_next = pos_reg; cnt_next = cnt_reg - 1'b1; end_next = cnt_next;
                    skip_next = 1'b0;
                    mode_next = 1'b0;
                end
                else
                begin
                    k_next = cnt_reg; end_next = cnt_reg;
                end
                sh_phase_next = 1'b0;
            end
            S_DONE:
            begin
                // wait here while the previous result is still held
                if (!ov_reg || out_ready)
                begin
                    out_st_next = st_reg; out_off_next = go_reg; out_size_next = gs_reg;
                    if (!opcode_reg && !mode_reg)
                    begin
                        if (bump_sum > {1'b0, pool_reg})
                            out_st_next = ST_OOM;
                        else
                        begin
                            out_off_next = bump_reg; out_size_next = need_reg[31:0];
                            bump_next = bump_sum[31:0];
                        end
                    end
                    ov_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // removal after merge reuses the shift-down walk
    state_t merge_next;
    assign merge_next = (state_reg == S_MERGE && k_next < end_next) ? S_SHIFT_DN : state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE; pool_reg <= POOL_RESET; bump_reg <= '0;
            cnt_reg <= '0; ov_reg <= 1'b0; sh_phase_reg <= 1'b0;
        end
        else
        begin
            state_reg <= merge_next;
            bump_reg <= bump_next; cnt_reg <= cnt_next; ov_reg <= ov_next;
            sh_phase_reg <= sh_phase_next;
            if (cfg_valid && cfg_ready)
                pool_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg <= k_next; pos_reg <= pos_next; end_reg <= end_next;
        need_reg <= need_next; off_reg <= off_next; size_reg <= size_next;
        poff_reg <= poff_next; psize_reg <= psize_next; pmerge_reg <= pmerge_next;
        mode_reg <= mode_next; st_reg <= st_next; go_reg <= go_next; gs_reg <= gs_next;
        skip_reg <= skip_next;
        out_st_reg <= out_st_next; out_off_reg <= out_off_next;
        out_size_reg <= out_size_next;
        if (in_valid && in_ready)
            opcode_reg <= opcode;
    end

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(FREE_SLOTS)) else $error("slot count overflow");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !in_ready) else $error("accept while busy");
    a_done_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) |=> out_valid) else $error("result lost");
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_OK) |-> (granted_offset == '0 && granted_size == '0))
        else $error("failure with nonzero grant");
`endif

endmodule

>>> bench/first_fit_region_allocator_unit_test.sv
// ----------------------------------------------------------------------------
// first_fit_region_allocator_unit_test: self-checking bench for the allocator
// Drives acquire/release beats with bursty valid and a stalling receiver,
// predicts every result with a local free-list model, checks in order.
// ----------------------------------------------------------------------------
module first_fit_region_allocator_unit_test;
    import ffra_pkg::*;

    typedef struct packed {
        status_t     st;
        logic [31:0] off;
        logic [31:0] len;
    } grant_t;

    class alloc_scoreboard;
        logic [31:0] pool;
        logic [31:0] bump;
        logic [31:0] free_off[$];
        logic [31:0] free_len[$];
        grant_t      pending_grants[$];
        int          errors;

        function new();
            pool = POOL_RESET;
            bump = '0;
            errors = 0;
        endfunction

        // end and merged size both computed without wrapping
        function bit adjacent(logic [31:0] lo_off, logic [31:0] lo_len,
                              logic [31:0] hi_off, logic [31:0] hi_len);
            longint unsigned lo_end, sum;
            lo_end = longint'(lo_off) + longint'(lo_len);
            sum = longint'(lo_len) + longint'(hi_len);
            return lo_end == longint'(hi_off) && sum <= 64'hFFFF_FFFF;
        endfunction

        function grant_t note_item(bit op, logic [31:0] sz, logic [31:0] off);
            grant_t g;
            longint unsigned need;
            int pos;
            bit hit;
            g.st = ST_OK;
            g.off = '0;
            g.len = '0;
            if (op == 1'b0) begin
                need = sz;
                need = ((need + MIN_REGION - 1) / MIN_REGION) * MIN_REGION;
                if (need < MIN_REGION)
                    need = MIN_REGION;
                hit = 0;
                for (int k = 0; k < free_len.size(); k++) begin
                    if (!hit && longint'(free_len[k]) >= need) begin
                        g.off = free_off[k];
                        g.len = free_len[k];
                        free_off.delete(k);
                        free_len.delete(k);
                        hit = 1;
                    end
                end
                if (!hit) begin
                    if (longint'(bump) + need > longint'(pool))
                        g.st = ST_OOM;
                    else begin
                        g.off = bump;
                        g.len = need[31:0];
                        bump = bump + need[31:0];
                    end
                end
            end else if (sz == '0)
                g.st = ST_ZERO;
            else if (free_off.size() >= FREE_SLOTS)
                g.st = ST_FULL;
            else begin
                pos = 0;
                while (pos < free_off.size() && free_off[pos] <= off)
                    pos++;
                free_off.insert(pos, off);
                free_len.insert(pos, sz);
                if (pos > 0 && adjacent(free_off[pos-1], free_len[pos-1], off, sz)) begin
                    free_len[pos-1] += sz;
                    free_off.delete(pos);
                    free_len.delete(pos);
                    pos--;
                end
                if (pos + 1 < free_off.size() &&
                    adjacent(free_off[pos], free_len[pos], free_off[pos+1], free_len[pos+1]))
                begin
                    free_len[pos] += free_len[pos+1];
                    free_off.delete(pos + 1);
                    free_len.delete(pos + 1);
                end
            end
            pending_grants.insert(pending_grants.size(), g);
            return g;
        endfunction

        function void check_result(grant_t got);
            grant_t exp;
            if (pending_grants.size() == 0) begin
                $error("result beat with nothing pending: status %0d", got.st);
                errors++;
                return;
            end
            exp = pending_grants.pop_front();
            if (got.st !== exp.st) begin
                $error("status: expected %0d, got %0d", exp.st, got.st);
                errors++;
            end
            if (got.off !== exp.off) begin
                $error("granted_offset: expected %h, got %h", exp.off, got.off);
                errors++;
            end
            if (got.len !== exp.len) begin
                $error("granted_size: expected %h, got %h", exp.len, got.len);
                errors++;
            end
        endfunction
    endclass

    localparam int STALL_LIMIT = 4000;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic        opcode;
    logic [31:0] region_size;
    logic [31:0] region_offset;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  status;
    logic [31:0] granted_offset;
    logic [31:0] granted_size;

    alloc_scoreboard sb;
    logic [31:0] held_off[$];
    logic [31:0] held_len[$];
    int          items_sent;
    int          burst_left;
    int          idle_cycles;

    first_fit_region_allocator_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .opcode         (opcode),
        .region_size    (region_size),
        .region_offset  (region_offset),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .granted_offset (granted_offset),
        .granted_size   (granted_size)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // watchdog: cycles with no beat on any channel
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver: random stalls, quiet stretches, one long hold-off
    initial
    begin
        int mode_left;
        bit held_once;
        int mode;
        out_ready = 1'b0;
        mode_left = 0;
        mode = 0;
        held_once = 0;
        forever begin
            @(negedge clk);
            if (!held_once && items_sent >= 150) begin
                held_once = 1;
                out_ready = 1'b0;
                repeat (400) @(negedge clk);
            end
            if (mode_left == 0) begin
                mode = $urandom_range(0, 2);
                mode_left = $urandom_range(5, 60);
            end
            mode_left--;
            case (mode)
                0: out_ready = 1'b1;
                1: out_ready = ($urandom_range(0, 3) != 0);
                default: out_ready = ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        grant_t got;
        if (rst_n && out_valid && out_ready) begin
            got.st = status_t'(status);
            got.off = granted_offset;
            got.len = granted_size;
            sb.check_result(got);
        end
    end

    task automatic send_item(bit op, logic [31:0] sz, logic [31:0] off);
        grant_t g;
        @(negedge clk);
        in_valid = 1'b1;
        opcode = op;
        region_size = sz;
        region_offset = off;
        do @(posedge clk); while (!in_ready);
        g = sb.note_item(op, sz, off);
        items_sent++;
        if (op == 1'b0 && g.st == ST_OK) begin
            held_off.insert(held_off.size(), g.off);
            held_len.insert(held_len.size(), g.len);
        end
        if (burst_left > 0)
            burst_left--;
        else begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(0, 8);
        end
    endtask

    task automatic write_pool(logic [31:0] val);
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.pending_grants.size() != 0)
            @(posedge clk);
        repeat (300) @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data = val;
        do @(posedge clk); while (!cfg_ready);
        sb.pool = val;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic random_item();
        int r;
        int idx;
        r = $urandom_range(0, 99);
        if (r < 45)
            send_item(1'b0, $urandom_range(0, 6 * MIN_REGION), $urandom);
        else if (r < 50)
            send_item(1'b0, $urandom, $urandom);
        else if (r < 85 && held_off.size() > 0) begin
            idx = $urandom_range(0, held_off.size() - 1);
            send_item(1'b1, held_len[idx], held_off[idx]);
            held_off.delete(idx);
            held_len.delete(idx);
        end else if (r < 90)
            send_item(1'b1, 32'd0, $urandom);
        else
            send_item(1'b1, $urandom, $urandom);
    endtask

    // spaced, non-touching regions overflow the free list
    task automatic fill_free_list();
        for (int k = 0; k < FREE_SLOTS + 4; k++)
            send_item(1'b1, MIN_REGION, 32'hF000_0000 + k * 2 * MIN_REGION);
        for (int k = 0; k < FREE_SLOTS; k++)
            send_item(1'b0, MIN_REGION, 32'd0);
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        in_valid = 1'b0;
        opcode = 1'b0;
        region_size = '0;
        region_offset = '0;
        items_sent = 0;
        burst_left = 0;
        idle_cycles = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: rounding, overflow, zero release, merges, equal offsets
        send_item(1'b0, 32'd0, 32'hFFFF_FFFF);
        send_item(1'b0, 32'd1, 32'd0);
        send_item(1'b0, MIN_REGION, 32'd0);
        send_item(1'b0, MIN_REGION + 1, 32'd0);
        send_item(1'b0, 32'hFFFF_FFFF, 32'd0);
        send_item(1'b0, 32'h1000_0000, 32'd0);
        send_item(1'b1, 32'd0, 32'h1234_5678);
        send_item(1'b1, MIN_REGION, 32'h0000_1000);
        send_item(1'b1, MIN_REGION, 32'h0000_3000);
        send_item(1'b1, MIN_REGION, 32'h0000_2000);
        send_item(1'b1, MIN_REGION, 32'h0000_2000);
        send_item(1'b0, 3 * MIN_REGION, 32'd0);
        send_item(1'b0, MIN_REGION, 32'd0);
        send_item(1'b1, 32'h8000_0000, 32'h0000_0000);
        send_item(1'b1, 32'h8000_0000, 32'h8000_0000);
        send_item(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(1'b0, 32'h8000_0000, 32'd0);
        send_item(1'b0, 32'h8000_0000, 32'd0);
        send_item(1'b0, 32'hFFFF_FFFF, 32'd0);
        held_off.delete();
        held_len.delete();

        write_pool(32'hFFFF_FFFF);
        for (int i = 0; i < 160; i++)
            random_item();
        fill_free_list();

        // pool below the bump pointer: only free-list grants succeed
        write_pool(32'd0);
        for (int i = 0; i < 80; i++)
            random_item();

        write_pool(32'h0010_0000 + $urandom_range(0, 32'h0010_0000));
        for (int i = 0; i < 150; i++)
            random_item();

        @(negedge clk);
        in_valid = 1'b0;
        while (sb.pending_grants.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
